// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL; rsq_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RSQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define RSQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rsq_pkg.sv =====
`default_nettype none
package rsq_pkg;
	localparam int unsigned MAX_ELEMENTS_DEF = 1024;
	localparam logic [10:0] LEN_RESET = 11'd1024;

	localparam logic [1:0] FUNC_ASSIGN = 2'd0;
	localparam logic [1:0] FUNC_ADD = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	typedef struct packed {
		logic [63:0] sum;
		logic [63:0] sq;
		logic        af;
		logic [15:0] av;
		logic        df;
		logic [63:0] dv;
	} node_t;

	typedef enum logic [1:0] {
		WSEL_ZERO,
		WSEL_W,
		WSEL_CLR,
		WSEL_REC
	} wsel_t;

	typedef enum logic [1:0] {
		VSEL_OP,
		VSEL_AV,
		VSEL_DV
	} vsel_t;

	typedef enum logic [1:0] {
		MSEL_SV,
		MSEL_P1V,
		MSEL_VSUM
	} msel_t;

	typedef struct packed {
		logic  mem_rd;
		logic  mem_wr;
		wsel_t wsel;
		logic  ld_w;
		logic  ld_cur;
		logic  ld_op;
		logic  ld_v;
		vsel_t vsel;
		logic  mul_go;
		msel_t msel;
		logic  fin_assign;
		logic  fin_add;
		logic  acc_clr;
		logic  acc_add;
		logic  ld_res;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic cur_af;
		logic cur_df;
	} stat_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_ENTER,
		S_T_RD,
		S_T_WR,
		S_M1,
		S_M1W,
		S_M2,
		S_M2W,
		S_M3,
		S_M3W,
		S_FIN_A,
		S_FIN_D,
		S_PD_RD,
		S_PD_CH,
		S_PD_CRD,
		S_PD_ADD,
		S_PD_CWR,
		S_PD_PWR,
		S_RET,
		S_REC_L,
		S_REC_LW,
		S_REC_R,
		S_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/core/rsq_mul.sv =====
`default_nettype none
module rsq_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      p
);
	// Product modulo 2^64 from three 32x32 partial products, one per cycle.
	logic [1:0]  step_q;
	logic        done_q;
	logic [63:0] a_q, b_q, acc_q;
	logic [31:0] x, y;
	logic [63:0] prod;

	always_comb begin
		case (step_q)
			2'd1: begin
				x = a_q[31:0];
				y = b_q[31:0];
			end
			2'd2: begin
				x = a_q[31:0];
				y = b_q[63:32];
			end
			default: begin
				x = a_q[63:32];
				y = b_q[31:0];
			end
		endcase
		prod = 64'(x) * 64'(y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == 2'd3);
			if (go)
				step_q <= 2'd1;
			else if (step_q == 2'd3)
				step_q <= 2'd0;
			else if (step_q != 2'd0)
				step_q <= step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= b;
		end
		if (step_q == 2'd1)
			acc_q <= prod;
		else if (step_q != 2'd0)
			acc_q <= acc_q + {prod[31:0], 32'd0};
	end

	assign done = done_q;
	assign p = acc_q;
endmodule
`default_nettype wire

// ===== rtl/core/rsq_datapath.sv =====
`default_nettype none
module rsq_datapath #(
	parameter int unsigned MAX_ELEMENTS = rsq_pkg::MAX_ELEMENTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rsq_pkg::cmd_t                cmd,
	input  wire logic [$clog2(MAX_ELEMENTS):0] addr,
	input  wire logic [$clog2(MAX_ELEMENTS):0] span,
	input  wire logic signed [15:0]           operand,
	output rsq_pkg::stat_t                    stat,
	output logic [63:0]                       result
);
	localparam int unsigned KW = $clog2(MAX_ELEMENTS) + 1;
	localparam int unsigned DEPTH = 2 ** KW;

	rsq_pkg::node_t mem [DEPTH];
	rsq_pkg::node_t rdata_q, w_q, cur_q, wdata;
	rsq_pkg::msel_t msel_q;
	logic [15:0] op_q;
	logic [63:0] v_q, v_d, p1_q, p2_q, p3_q, acc_q, res_q;
	logic [63:0] ma, mb, mp;
	logic        mdone;

	always_comb begin
		case (cmd.wsel)
			rsq_pkg::WSEL_W: wdata = w_q;
			rsq_pkg::WSEL_CLR: begin
				wdata = '0;
				wdata.sum = cur_q.sum;
				wdata.sq = cur_q.sq;
			end
			rsq_pkg::WSEL_REC: begin
				wdata = '0;
				wdata.sum = w_q.sum + rdata_q.sum;
				wdata.sq = w_q.sq + rdata_q.sq;
			end
			default: wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr)
			mem[addr] <= wdata;
		if (cmd.mem_rd)
			rdata_q <= mem[addr];
	end

	always_comb begin
		case (cmd.vsel)
			rsq_pkg::VSEL_AV: v_d = {{48{cur_q.av[15]}}, cur_q.av};
			rsq_pkg::VSEL_DV: v_d = cur_q.dv;
			default: v_d = {{48{op_q[15]}}, op_q};
		endcase
		case (cmd.msel)
			rsq_pkg::MSEL_P1V: begin
				ma = p1_q;
				mb = v_q;
			end
			rsq_pkg::MSEL_VSUM: begin
				ma = v_q;
				mb = w_q.sum;
			end
			default: begin
				ma = 64'(span);
				mb = v_q;
			end
		endcase
	end

	rsq_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.a      (ma),
		.b      (mb),
		.done   (mdone),
		.p      (mp)
	);

	always_ff @(posedge clk) begin
		if (cmd.ld_op)
			op_q <= operand;
		if (cmd.ld_v)
			v_q <= v_d;
		if (cmd.ld_cur)
			cur_q <= rdata_q;
		if (cmd.mul_go)
			msel_q <= cmd.msel;
		if (mdone) begin
			case (msel_q)
				rsq_pkg::MSEL_P1V: p2_q <= mp;
				rsq_pkg::MSEL_VSUM: p3_q <= mp;
				default: p1_q <= mp;
			endcase
		end
		if (cmd.ld_w) begin
			w_q <= rdata_q;
		end else if (cmd.fin_assign) begin
			w_q.sum <= p1_q;
			w_q.sq <= p2_q;
			w_q.af <= 1'b1;
			w_q.av <= v_q[15:0];
			w_q.df <= 1'b0;
			w_q.dv <= 64'd0;
		end else if (cmd.fin_add) begin
			w_q.sum <= w_q.sum + p1_q;
			w_q.sq <= w_q.sq + p2_q + {p3_q[62:0], 1'b0};
			w_q.df <= 1'b1;
			w_q.dv <= w_q.dv + v_q;
		end
		if (cmd.acc_clr)
			acc_q <= 64'd0;
		else if (cmd.acc_add)
			acc_q <= acc_q + rdata_q.sq;
		if (cmd.ld_res)
			res_q <= acc_q;
	end

	assign stat.mul_done = mdone;
	assign stat.cur_af = cur_q.af;
	assign stat.cur_df = cur_q.df;
	assign result = res_q;
endmodule
`default_nettype wire

// ===== rtl/core/rsq_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module rsq_ctrl #(
	parameter int unsigned MAX_ELEMENTS = rsq_pkg::MAX_ELEMENTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    func,
	input  wire logic [9:0]                    range_start,
	input  wire logic [9:0]                    range_end,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	input  wire logic [10:0]                   len,
	output rsq_pkg::cmd_t                      cmd,
	output logic [$clog2(MAX_ELEMENTS):0]      addr,
	output logic [$clog2(MAX_ELEMENTS):0]      span,
	input  wire rsq_pkg::stat_t                stat
);
	localparam int unsigned IW = $clog2(MAX_ELEMENTS);
	localparam int unsigned KW = IW + 1;
	localparam int unsigned CW = (IW > 10) ? IW : 10;
	localparam int unsigned LW = (IW + 1 > 11) ? IW + 1 : 11;
	localparam int unsigned SD = IW;
	localparam int unsigned PW = $clog2(SD + 1);
	localparam int unsigned TI = (SD > 1) ? $clog2(SD) : 1;

	rsq_pkg::state_t state_q, state_d, ret_q, ret_d;
	logic [KW-1:0] k_q, k_d, clr_q, clr_d;
	logic [IW-1:0] lo_q, lo_d, hi_q, hi_d, last, mid, top_mid, top_lo, top_hi;
	logic [KW-1:0] top_k;
	logic          top_ph;
	logic [PW-1:0] sp_q, sp_d;
	logic [IW:0]   span_q, span_d, span_t, span_l, span_r, lohi, top_lohi;
	logic [9:0]    qs_q, qs_d, qe_q, qe_d;
	logic          chs_q, chs_d, pk_q, pk_d, qry_q, qry_d, asg_q, asg_d;
	logic          ov_q, ov_d, push, set_ph;
	logic [LW-1:0] len_x, len_m1;
	logic [CW-1:0] qs_c, qe_c, lo_c, hi_c;
	logic          outside, full;

	logic [KW-1:0] stk_k [SD];
	logic [IW-1:0] stk_lo [SD];
	logic [IW-1:0] stk_hi [SD];
	logic          stk_ph [SD];

	always_comb begin
		len_x = LW'(len);
		len_m1 = len_x - LW'(1);
		if (len_x == LW'(0))
			last = '0;
		else if (len_x > LW'(MAX_ELEMENTS))
			last = IW'(MAX_ELEMENTS - 1);
		else
			last = len_m1[IW-1:0];
		lohi = {1'b0, lo_q} + {1'b0, hi_q};
		mid = lohi[IW:1];
		span_t = {1'b0, hi_q} - {1'b0, lo_q} + (IW+1)'(1);
		span_l = {1'b0, mid} - {1'b0, lo_q} + (IW+1)'(1);
		span_r = {1'b0, hi_q} - {1'b0, mid};
		qs_c = CW'(qs_q);
		qe_c = CW'(qe_q);
		lo_c = CW'(lo_q);
		hi_c = CW'(hi_q);
		outside = (qs_c > hi_c) || (qe_c < lo_c);
		full = (qs_c <= lo_c) && (qe_c >= hi_c);
		top_k = stk_k[TI'(sp_q - PW'(1))];
		top_lo = stk_lo[TI'(sp_q - PW'(1))];
		top_hi = stk_hi[TI'(sp_q - PW'(1))];
		top_ph = stk_ph[TI'(sp_q - PW'(1))];
		top_lohi = {1'b0, top_lo} + {1'b0, top_hi};
		top_mid = top_lohi[IW:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsq_pkg::S_CLEAR;
			ret_q <= rsq_pkg::S_IDLE;
			clr_q <= '0;
			sp_q <= '0;
			ov_q <= 1'b0;
			k_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			span_q <= '0;
			qs_q <= '0;
			qe_q <= '0;
			chs_q <= 1'b0;
			pk_q <= 1'b0;
			qry_q <= 1'b0;
			asg_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			clr_q <= clr_d;
			sp_q <= sp_d;
			ov_q <= ov_d;
			k_q <= k_d;
			lo_q <= lo_d;
			hi_q <= hi_d;
			span_q <= span_d;
			qs_q <= qs_d;
			qe_q <= qe_d;
			chs_q <= chs_d;
			pk_q <= pk_d;
			qry_q <= qry_d;
			asg_q <= asg_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stk_k[TI'(sp_q)] <= k_q;
			stk_lo[TI'(sp_q)] <= lo_q;
			stk_hi[TI'(sp_q)] <= hi_q;
			stk_ph[TI'(sp_q)] <= 1'b0;
		end else if (set_ph) begin
			stk_ph[TI'(sp_q - PW'(1))] <= 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		clr_d = clr_q;
		sp_d = sp_q;
		ov_d = ov_q && out_stall;
		k_d = k_q;
		lo_d = lo_q;
		hi_d = hi_q;
		span_d = span_q;
		qs_d = qs_q;
		qe_d = qe_q;
		chs_d = chs_q;
		pk_d = pk_q;
		qry_d = qry_q;
		asg_d = asg_q;
		push = 1'b0;
		set_ph = 1'b0;
		cmd = '0;
		addr = k_q;
		in_stall = 1'b1;
		unique case (state_q)
			rsq_pkg::S_CLEAR: begin
				cmd.mem_wr = 1'b1;
				cmd.wsel = rsq_pkg::WSEL_ZERO;
				addr = clr_q;
				clr_d = clr_q + KW'(1);
				if (&clr_q)
					state_d = rsq_pkg::S_IDLE;
			end
			rsq_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.ld_op = 1'b1;
					cmd.acc_clr = 1'b1;
					qs_d = range_start;
					qe_d = range_end;
					qry_d = (func == rsq_pkg::FUNC_QUERY);
					asg_d = (func == rsq_pkg::FUNC_ASSIGN);
					k_d = KW'(1);
					lo_d = '0;
					hi_d = last;
					sp_d = '0;
					if (range_start <= range_end && (func == rsq_pkg::FUNC_QUERY
						|| func == rsq_pkg::FUNC_ASSIGN || func == rsq_pkg::FUNC_ADD))
						state_d = rsq_pkg::S_ENTER;
					else if (func == rsq_pkg::FUNC_QUERY)
						state_d = rsq_pkg::S_OUT;
				end
			end
			rsq_pkg::S_ENTER: begin
				if (outside) begin
					state_d = rsq_pkg::S_RET;
				end else begin
					cmd.mem_rd = 1'b1;
					if (full) begin
						span_d = span_t;
						state_d = rsq_pkg::S_T_RD;
					end else begin
						state_d = rsq_pkg::S_PD_RD;
					end
				end
			end
			rsq_pkg::S_T_RD: begin
				if (qry_q) begin
					cmd.acc_add = 1'b1;
					state_d = rsq_pkg::S_RET;
				end else begin
					cmd.ld_w = 1'b1;
					cmd.ld_v = 1'b1;
					cmd.vsel = rsq_pkg::VSEL_OP;
					pk_d = asg_q;
					ret_d = rsq_pkg::S_T_WR;
					state_d = rsq_pkg::S_M1;
				end
			end
			rsq_pkg::S_T_WR: begin
				cmd.mem_wr = 1'b1;
				cmd.wsel = rsq_pkg::WSEL_W;
				state_d = rsq_pkg::S_RET;
			end
			rsq_pkg::S_M1: begin
				cmd.mul_go = 1'b1;
				cmd.msel = rsq_pkg::MSEL_SV;
				state_d = rsq_pkg::S_M1W;
			end
			rsq_pkg::S_M1W: begin
				if (stat.mul_done)
					state_d = rsq_pkg::S_M2;
			end
			rsq_pkg::S_M2: begin
				cmd.mul_go = 1'b1;
				cmd.msel = rsq_pkg::MSEL_P1V;
				state_d = rsq_pkg::S_M2W;
			end
			rsq_pkg::S_M2W: begin
				if (stat.mul_done)
					state_d = pk_q ? rsq_pkg::S_FIN_A : rsq_pkg::S_M3;
			end
			rsq_pkg::S_M3: begin
				cmd.mul_go = 1'b1;
				cmd.msel = rsq_pkg::MSEL_VSUM;
				state_d = rsq_pkg::S_M3W;
			end
			rsq_pkg::S_M3W: begin
				if (stat.mul_done)
					state_d = rsq_pkg::S_FIN_D;
			end
			rsq_pkg::S_FIN_A: begin
				cmd.fin_assign = 1'b1;
				state_d = ret_q;
			end
			rsq_pkg::S_FIN_D: begin
				cmd.fin_add = 1'b1;
				state_d = ret_q;
			end
			rsq_pkg::S_PD_RD: begin
				cmd.ld_cur = 1'b1;
				chs_d = 1'b0;
				state_d = rsq_pkg::S_PD_CH;
			end
			rsq_pkg::S_PD_CH: begin
				cmd.mem_rd = 1'b1;
				addr = {k_q[KW-2:0], chs_q};
				span_d = chs_q ? span_r : span_l;
				state_d = rsq_pkg::S_PD_CRD;
			end
			rsq_pkg::S_PD_CRD: begin
				cmd.ld_w = 1'b1;
				if (stat.cur_af) begin
					cmd.ld_v = 1'b1;
					cmd.vsel = rsq_pkg::VSEL_AV;
					pk_d = 1'b1;
					ret_d = rsq_pkg::S_PD_ADD;
					state_d = rsq_pkg::S_M1;
				end else begin
					state_d = rsq_pkg::S_PD_ADD;
				end
			end
			rsq_pkg::S_PD_ADD: begin
				if (stat.cur_df) begin
					cmd.ld_v = 1'b1;
					cmd.vsel = rsq_pkg::VSEL_DV;
					pk_d = 1'b0;
					ret_d = rsq_pkg::S_PD_CWR;
					state_d = rsq_pkg::S_M1;
				end else begin
					state_d = rsq_pkg::S_PD_CWR;
				end
			end
			rsq_pkg::S_PD_CWR: begin
				cmd.mem_wr = 1'b1;
				cmd.wsel = rsq_pkg::WSEL_W;
				addr = {k_q[KW-2:0], chs_q};
				if (!chs_q) begin
					chs_d = 1'b1;
					state_d = rsq_pkg::S_PD_CH;
				end else begin
					state_d = rsq_pkg::S_PD_PWR;
				end
			end
			rsq_pkg::S_PD_PWR: begin
				cmd.mem_wr = 1'b1;
				cmd.wsel = rsq_pkg::WSEL_CLR;
				push = 1'b1;
				sp_d = sp_q + PW'(1);
				k_d = {k_q[KW-2:0], 1'b0};
				hi_d = mid;
				state_d = rsq_pkg::S_ENTER;
			end
			rsq_pkg::S_RET: begin
				if (sp_q == '0) begin
					state_d = qry_q ? rsq_pkg::S_OUT : rsq_pkg::S_IDLE;
				end else if (!top_ph) begin
					set_ph = 1'b1;
					k_d = {top_k[KW-2:0], 1'b1};
					lo_d = top_mid + IW'(1);
					hi_d = top_hi;
					state_d = rsq_pkg::S_ENTER;
				end else begin
					sp_d = sp_q - PW'(1);
					if (!qry_q) begin
						k_d = top_k;
						state_d = rsq_pkg::S_REC_L;
					end
				end
			end
			rsq_pkg::S_REC_L: begin
				cmd.mem_rd = 1'b1;
				addr = {k_q[KW-2:0], 1'b0};
				state_d = rsq_pkg::S_REC_LW;
			end
			rsq_pkg::S_REC_LW: begin
				cmd.ld_w = 1'b1;
				cmd.mem_rd = 1'b1;
				addr = {k_q[KW-2:0], 1'b1};
				state_d = rsq_pkg::S_REC_R;
			end
			rsq_pkg::S_REC_R: begin
				cmd.mem_wr = 1'b1;
				cmd.wsel = rsq_pkg::WSEL_REC;
				state_d = rsq_pkg::S_RET;
			end
			rsq_pkg::S_OUT: begin
				if (!ov_q || !out_stall) begin
					cmd.ld_res = 1'b1;
					ov_d = 1'b1;
					state_d = rsq_pkg::S_IDLE;
				end
			end
			default: state_d = rsq_pkg::S_IDLE;
		endcase
	end

	assign out_valid = ov_q;
	assign span = span_q;

	`RSQ_ASSERT(a_sp_bound, sp_q <= PW'(SD), "Traversal stack deeper than the tree.")
	`RSQ_ASSERT_IMP(a_out_from_query, $rose(ov_q), $past(state_q == rsq_pkg::S_OUT), "Result without a query.")
	`RSQ_ASSERT_IMP(a_mul_done_wait, stat.mul_done, (state_q == rsq_pkg::S_M1W || state_q == rsq_pkg::S_M2W || state_q == rsq_pkg::S_M3W), "Product done outside a wait state.")
endmodule
`default_nettype wire

// ===== rtl/core/range_assign_add_sum_of_squares.sv =====
// Channel   Handshake             Payload
// in        in_valid / in_stall   func, range_start, range_end, operand_value
// out       out_valid / out_stall sum_of_squares
// cfg       cfg_valid / cfg_ready length_in_use
//
// One item at a time. An unused selector is taken and dropped without leaving idle, and a
// reversed-range query goes straight to the output state; other items grow with the tree
// nodes visited, the most for an update that pushes pending assigns and adds down both
// edges of its range through the memory. A put costs two 64-bit products for an assign or
// three for an add. After reset all 2**(clog2(MAX_ELEMENTS)+1) node memory entries are
// cleared with in_stall high; a finished result waits in the output register while the next item enters.
`default_nettype none
module range_assign_add_sum_of_squares #(
	parameter int unsigned MAX_ELEMENTS = rsq_pkg::MAX_ELEMENTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         func,
	input  wire logic [9:0]         range_start,
	input  wire logic [9:0]         range_end,
	input  wire logic signed [15:0] operand_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [63:0]      sum_of_squares,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [10:0]        length_in_use
);
	localparam int unsigned IW = $clog2(MAX_ELEMENTS);

	rsq_pkg::cmd_t  cmd;
	rsq_pkg::stat_t stat;
	logic [IW:0]    addr, span;
	logic [10:0]    len_q;
	logic [63:0]    result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			len_q <= rsq_pkg::LEN_RESET;
		else if (cfg_valid)
			len_q <= length_in_use;
	end

	assign cfg_ready = 1'b1;

	rsq_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.range_start (range_start),
		.range_end   (range_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.len         (len_q),
		.cmd         (cmd),
		.addr        (addr),
		.span        (span),
		.stat        (stat)
	);

	rsq_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.addr    (addr),
		.span    (span),
		.operand (operand_value),
		.stat    (stat),
		.result  (result)
	);

	assign sum_of_squares = result;
endmodule
`default_nettype wire

// ===== tb/sv/tb_range_assign_add_sum_of_squares.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_range_assign_add_sum_of_squares;
	localparam int NODES = 4096;
	localparam int WATCHDOG_LIMIT = 30000;
	localparam int DRAIN_CYCLES = 600;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [9:0]  rs;
		logic [9:0]  re;
		logic [15:0] val;
	} op_item_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] func;
	logic [9:0] range_start;
	logic [9:0] range_end;
	logic signed [15:0] operand_value;
	logic out_valid;
	logic out_stall;
	logic signed [63:0] sum_of_squares;
	logic cfg_valid;
	logic cfg_ready;
	logic [10:0] length_in_use;

	range_assign_add_sum_of_squares u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.range_start(range_start),
		.range_end(range_end),
		.operand_value(operand_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sum_of_squares(sum_of_squares),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.length_in_use(length_in_use)
	);

	bit [63:0] t_sum [NODES];
	bit [63:0] t_sq [NODES];
	bit        t_af [NODES];
	bit [63:0] t_av [NODES];
	bit        t_df [NODES];
	bit [63:0] t_dv [NODES];
	bit [10:0] model_len;

	op_item_t pending_ops[$];
	logic [63:0] expected_sq[$];
	int errors;
	int idle_cycles;
	bit holding;
	int send_gap;
	bit no_gaps;
	int hold_requests;
	int hold_seen;
	int hold_left;
	int stall_left;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	function automatic void set_node(int k, bit [63:0] span, bit [63:0] v);
		t_af[k] = 1'b1;
		t_av[k] = v;
		t_df[k] = 1'b0;
		t_dv[k] = '0;
		t_sum[k] = span * v;
		t_sq[k] = span * v * v;
	endfunction

	function automatic void add_node(int k, bit [63:0] span, bit [63:0] v);
		t_df[k] = 1'b1;
		t_dv[k] = t_dv[k] + v;
		t_sq[k] = t_sq[k] + span * v * v + 64'd2 * v * t_sum[k];
		t_sum[k] = t_sum[k] + span * v;
	endfunction

	function automatic void push_lazy(int k, int lo, int hi, int mid);
		bit [63:0] ls;
		bit [63:0] rspan;
		ls = 64'(mid - lo + 1);
		rspan = 64'(hi - mid);
		if (t_af[k]) begin
			set_node(2 * k, ls, t_av[k]);
			set_node(2 * k + 1, rspan, t_av[k]);
		end
		t_af[k] = 1'b0;
		t_av[k] = '0;
		if (t_df[k]) begin
			add_node(2 * k, ls, t_dv[k]);
			add_node(2 * k + 1, rspan, t_dv[k]);
		end
		t_df[k] = 1'b0;
		t_dv[k] = '0;
	endfunction

	function automatic void range_update(int qs, int qe, int lo, int hi, int k, bit is_set,
			bit [63:0] v);
		int mid;
		if (qs > hi || qe < lo || 2 * k + 1 >= NODES)
			return;
		if (qs <= lo && qe >= hi) begin
			if (is_set)
				set_node(k, 64'(hi - lo + 1), v);
			else
				add_node(k, 64'(hi - lo + 1), v);
			return;
		end
		mid = (lo + hi) / 2;
		push_lazy(k, lo, hi, mid);
		range_update(qs, qe, lo, mid, 2 * k, is_set, v);
		range_update(qs, qe, mid + 1, hi, 2 * k + 1, is_set, v);
		t_sum[k] = t_sum[2 * k] + t_sum[2 * k + 1];
		t_sq[k] = t_sq[2 * k] + t_sq[2 * k + 1];
	endfunction

	function automatic bit [63:0] range_squares(int qs, int qe, int lo, int hi, int k);
		int mid;
		bit [63:0] left;
		if (qs > hi || qe < lo || 2 * k + 1 >= NODES)
			return '0;
		if (qs <= lo && qe >= hi)
			return t_sq[k];
		mid = (lo + hi) / 2;
		push_lazy(k, lo, hi, mid);
		left = range_squares(qs, qe, lo, mid, 2 * k);
		return left + range_squares(qs, qe, mid + 1, hi, 2 * k + 1);
	endfunction

	function automatic void apply_op(op_item_t it);
		int len;
		bit [63:0] v;
		len = model_len;
		if (len < 1)
			len = 1;
		if (len > 1024)
			len = 1024;
		v = {{48{it.val[15]}}, it.val};
		if (it.func == rsq_pkg::FUNC_QUERY)
			expected_sq.insert(expected_sq.size(), (it.rs <= it.re) ?
				range_squares(it.rs, it.re, 0, len - 1, 1) : 64'd0);
		else if ((it.func == rsq_pkg::FUNC_ASSIGN || it.func == rsq_pkg::FUNC_ADD)
				&& it.rs <= it.re)
			range_update(it.rs, it.re, 0, len - 1, 1, it.func == rsq_pkg::FUNC_ASSIGN, v);
	endfunction

	always @(negedge clk or negedge arst_n) begin
		op_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= rsq_pkg::FUNC_QUERY;
			range_start <= '0;
			range_end <= '0;
			operand_value <= '0;
			holding = 1'b0;
			send_gap = 0;
		end else if (!holding) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				it = pending_ops.pop_front();
				func <= it.func;
				range_start <= it.rs;
				range_end <= it.re;
				operand_value <= it.val;
				in_valid <= 1'b1;
				holding = 1'b1;
				if (no_gaps)
					send_gap = 0;
				else if ($urandom_range(0, 15) == 0)
					send_gap = $urandom_range(20, 120);
				else
					send_gap = $urandom_range(0, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_seen = 0;
			hold_left = 0;
			stall_left = 0;
		end else begin
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = 2500;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
				stall_left = ($urandom_range(0, 12) == 0) ? $urandom_range(20, 150)
					: $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		op_item_t it;
		logic [63:0] want;
		if (arst_n) begin
			idle_cycles++;
			if (cfg_valid && cfg_ready) begin
				model_len = length_in_use;
				idle_cycles = 0;
			end
			if (in_valid && !in_stall) begin
				it = '{func, range_start, range_end, operand_value};
				apply_op(it);
				holding = 1'b0;
				idle_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				if (expected_sq.size() == 0) begin
					report("unexpected result", sum_of_squares, '0);
				end else begin
					want = expected_sq.pop_front();
					if (sum_of_squares !== want)
						report("sum_of_squares", sum_of_squares, want);
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL range_assign_add_sum_of_squares");
				$finish;
			end
		end
	end

	task automatic push_op(input logic [1:0] f, input int rs, input int re, input int v);
		op_item_t it;
		it.func = f;
		it.rs = rs[9:0];
		it.re = re[9:0];
		it.val = v[15:0];
		pending_ops.insert(pending_ops.size(), it);
	endtask

	task automatic wait_idle();
		while (pending_ops.size() > 0 || holding || expected_sq.size() > 0 || in_stall)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [10:0] len);
		@(negedge clk);
		cfg_valid <= 1'b1;
		length_in_use <= len;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_ops(input int count, input int len);
		int lim;
		int a;
		int b;
		int r;
		logic [1:0] f;
		lim = (len < 1) ? 1 : ((len > 1024) ? 1024 : len);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			f = (r < 35) ? rsq_pkg::FUNC_ASSIGN : (r < 65) ? rsq_pkg::FUNC_ADD
				: (r < 97) ? rsq_pkg::FUNC_QUERY : FUNC_NONE;
			r = $urandom_range(0, 19);
			if (r == 0) begin
				a = $urandom_range(0, 1023);
				b = $urandom_range(0, 1023);
			end else if (r < 8) begin
				a = $urandom_range(0, lim - 1);
				b = a;
			end else begin
				a = $urandom_range(0, lim - 1);
				b = $urandom_range(a, (a + 40 < lim) ? a + 40 : lim - 1);
				if (r == 19)
					b = lim - 1;
			end
			push_op(f, a, b, $urandom_range(0, 65535));
		end
	endtask

	initial begin
		logic [10:0] lengths [7];
		errors = 0;
		idle_cycles = 0;
		hold_requests = 0;
		no_gaps = 1'b0;
		model_len = rsq_pkg::LEN_RESET;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		length_in_use = rsq_pkg::LEN_RESET;
		out_stall = 1'b0;
		in_valid = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_op(rsq_pkg::FUNC_QUERY, 0, 1023, 0);
		push_op(rsq_pkg::FUNC_ASSIGN, 0, 1023, 32767);
		push_op(rsq_pkg::FUNC_QUERY, 0, 1023, 0);
		push_op(rsq_pkg::FUNC_ASSIGN, 1023, 1023, -32768);
		push_op(rsq_pkg::FUNC_ADD, 500, 1023, -32768);
		push_op(rsq_pkg::FUNC_QUERY, 1000, 1023, 0);
		push_op(rsq_pkg::FUNC_ADD, 0, 1023, 32767);
		push_op(rsq_pkg::FUNC_ASSIGN, 10, 20, -1);
		push_op(rsq_pkg::FUNC_ADD, 15, 30, 1);
		push_op(rsq_pkg::FUNC_QUERY, 0, 0, 0);
		push_op(rsq_pkg::FUNC_QUERY, 12, 25, 0);
		push_op(rsq_pkg::FUNC_QUERY, 25, 12, 0);
		push_op(rsq_pkg::FUNC_ASSIGN, 40, 30, 999);
		push_op(FUNC_NONE, 0, 1023, 1234);
		push_op(rsq_pkg::FUNC_QUERY, 0, 1023, 0);
		wait_idle();

		lengths = '{11'd37, 11'd1, 11'd2, 11'd0, 11'd2047, 11'd1000, 11'd1024};
		foreach (lengths[p]) begin
			write_length(lengths[p]);
			push_op(rsq_pkg::FUNC_QUERY, 0, 1023, 0);
			push_op(rsq_pkg::FUNC_ADD, 0, 1023, 3);
			push_op(rsq_pkg::FUNC_QUERY, 0, 1023, 0);
			push_op(rsq_pkg::FUNC_ASSIGN, 1023, 1023, 7);
			push_op(rsq_pkg::FUNC_QUERY, 1000, 1023, 0);
			random_ops(60, lengths[p]);
			if (p == 1) begin
				hold_requests++;
				random_ops(20, lengths[p]);
			end
			if (p == 3) begin
				wait_idle();
				no_gaps = 1'b1;
				random_ops(60, lengths[p]);
				while (pending_ops.size() > 0)
					@(posedge clk);
				no_gaps = 1'b0;
			end
			if (p == 6) begin
				random_ops(300, lengths[p]);
				wait_idle();
				random_ops(300, lengths[p]);
			end
			wait_idle();
		end

		if (errors == 0 && expected_sq.size() == 0)
			$display("PASS range_assign_add_sum_of_squares");
		else
			$display("FAIL range_assign_add_sum_of_squares");
		$finish;
	end
endmodule
`default_nettype wire
